[rtl/core/spike_burst_statistics_unit_macros.svh]
// ----------------------------------------------------------------------------
// Spike burst statistics assertion macros
// Shared assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SPIKE_BURST_STATISTICS_UNIT_MACROS_SVH
`define SPIKE_BURST_STATISTICS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SBS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBS_ASSERT(lbl, clk, rst, prop, msg)
`define SBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// Spike burst statistics package
// Payload types, register indexes, divider interface and shared constants.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int RATE_FRAC_BITS = 24;
  localparam int TIME_BITS      = 32;
  localparam int COUNT_BITS     = 16;
  localparam int SUM_BITS       = 40;
  localparam int GAP_BITS       = 24;
  localparam int RATE_BITS      = 25;
  localparam int DUTY_BITS      = 17;
  localparam int DUTY_FRAC_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  // The shared divider covers the widest dividend, duration shifted by 16.
  localparam int DIV_NUM_BITS = TIME_BITS + DUTY_FRAC_BITS;
  localparam int DIV_DEN_BITS = TIME_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPIKE_LEVEL  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TROUGH_LEVEL = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_SAMPLES  = 2'd2;

  localparam logic signed [SAMPLE_BITS-1:0] SPIKE_LEVEL_RESET  = -16'sd3;
  localparam logic signed [SAMPLE_BITS-1:0] TROUGH_LEVEL_RESET = -16'sd13568;
  localparam logic [GAP_BITS-1:0]           GAP_SAMPLES_RESET  = 24'd400;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  localparam logic [DIV_NUM_BITS-1:0] ONE_RATE  = DIV_NUM_BITS'(1) << RATE_FRAC_BITS;
  localparam logic [DIV_NUM_BITS-1:0] ONE_DUTY  = DIV_NUM_BITS'(1) << DUTY_FRAC_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          trace_end;
  } sbs_in_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  burst_start;
    logic [TIME_BITS-1:0]  burst_duration;
    logic [TIME_BITS-1:0]  burst_period;
    logic [COUNT_BITS-1:0] spike_count;
    logic [RATE_BITS-1:0]  mean_rate;
    logic [DUTY_BITS-1:0]  duty_cycle;
    logic [TIME_BITS-1:0]  interburst_gap;
    logic                  single_spike;
  } sbs_out_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_NUM_BITS-1:0] dividend;
    logic [DIV_DEN_BITS-1:0] divisor;
  } sbs_div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [DIV_NUM_BITS-1:0] quotient;
  } sbs_div_rsp_t;

endpackage

[rtl/core/sbs_divider.sv]
// ----------------------------------------------------------------------------
// Spike burst statistics shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "spike_burst_statistics_unit_macros.svh"

module sbs_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  sbs_pkg::sbs_div_req_t req,
  output sbs_pkg::sbs_div_rsp_t rsp
);
  import sbs_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_NUM_BITS + 1);

  logic [DIV_NUM_BITS-1:0] quo;
  logic [DIV_DEN_BITS-1:0] rem;
  logic [DIV_DEN_BITS-1:0] den;
  logic [CNT_BITS-1:0]     count;
  logic                    busy;
  logic                    done;
  logic [DIV_DEN_BITS:0]   trial;
  logic                    fits;

  assign trial = {rem, quo[DIV_NUM_BITS-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(DIV_NUM_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_BITS-2:0], fits};
      rem <= fits ? DIV_DEN_BITS'(trial - {1'b0, den}) : trial[DIV_DEN_BITS-1:0];
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  `SBS_ASSERT(a_start_idle, clk, rst, req.start |-> !busy, "divider started while busy")
  `SBS_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy), "done without a running divide")
  `SBS_ASSERT(a_rose_on_start, clk, rst, $rose(busy) |-> $past(req.start), "busy without a start")
  `SBS_ASSERT_ALWAYS(a_done_not_busy, clk, done |-> !busy, "done while still busy")

endmodule

[rtl/core/spike_burst_statistics_unit.sv]
// ----------------------------------------------------------------------------
// Spike burst statistics unit
// Spike and burst detector on a membrane-voltage stream with burst records.
// ----------------------------------------------------------------------------
// The unit takes one Q8 millivolt sample per item and reports one record per
// closed burst. A sample that does not end a spike needs no divide. A sample
// that ends a spike inside the current burst holds off the next one while the
// reciprocal of the inter-spike interval is formed in the shared 48-step
// restoring divider. A sample that ends a spike and closes a burst holds off
// the next one until the record is in the output register: the mean rate and
// the duty cycle are two passes through that same divider. A single-spike
// burst skips the rate pass, and a zero period skips the duty pass. in_ready
// is low while the divider sequence runs.
// A finished record sits in the output register; the next sample is taken
// while it waits, and the unit only holds off when a second record is ready
// before the first has been taken. Configuration is written at any time
// through the cfg channel and should change only while the unit is idle.
`include "spike_burst_statistics_unit_macros.svh"

module spike_burst_statistics_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sbs_pkg::sbs_in_t                     in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sbs_pkg::sbs_out_t                    out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sbs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sbs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import sbs_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'b001,
    PH_LOW   = 3'b010,
    PH_SPIKE = 3'b100
  } phase_t;

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_RATE_GO    = 8'b0000_0010,
    S_RATE_WAIT  = 8'b0000_0100,
    S_DUTY_GO    = 8'b0000_1000,
    S_DUTY_WAIT  = 8'b0001_0000,
    S_RECIP_GO   = 8'b0010_0000,
    S_RECIP_WAIT = 8'b0100_0000,
    S_OUT        = 8'b1000_0000
  } seq_t;

  // Configuration registers.
  logic signed [SAMPLE_BITS-1:0] spike_level;
  logic signed [SAMPLE_BITS-1:0] trough_level;
  logic [GAP_BITS-1:0]           gap_samples;

  // Detector state.
  phase_t                        phase, phase_next;
  logic [TIME_BITS-1:0]          sample_index, sample_index_next;
  logic signed [SAMPLE_BITS-1:0] peak_value, peak_value_next;
  logic [TIME_BITS-1:0]          peak_index, peak_index_next;
  logic [TIME_BITS-1:0]          previous_peak, previous_peak_next;
  logic                          have_previous, have_previous_next;
  logic signed [SAMPLE_BITS-1:0] trough_min, trough_min_next;
  logic                          burst_open, burst_open_next;
  logic [TIME_BITS-1:0]          burst_first, burst_first_next;
  logic [COUNT_BITS-1:0]         burst_spikes, burst_spikes_next;
  logic [SUM_BITS-1:0]           rate_sum, rate_sum_next;

  // Sequencer and operands of the shared divider.
  seq_t                    seq;
  sbs_out_t                rec, rec_next;
  logic [DIV_NUM_BITS-1:0] op_num;
  logic [DIV_DEN_BITS-1:0] op_den;
  logic                    rec_fire;
  logic                    recip_fire;
  logic [TIME_BITS-1:0]    gap;
  logic                    high;
  logic                    in_fire;
  logic                    out_load;
  logic [SUM_BITS:0]       sum_wide;
  sbs_div_req_t            div_req;
  sbs_div_rsp_t            div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_level  <= SPIKE_LEVEL_RESET;
      trough_level <= TROUGH_LEVEL_RESET;
      gap_samples  <= GAP_SAMPLES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPIKE_LEVEL:  spike_level  <= cfg_data[SAMPLE_BITS-1:0];
        REG_TROUGH_LEVEL: trough_level <= cfg_data[SAMPLE_BITS-1:0];
        REG_GAP_SAMPLES:  gap_samples  <= cfg_data[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (seq == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign high     = in_item.sample > spike_level;
  assign gap      = peak_index - previous_peak;

  // One sample step. Everything except the divisions settles here; a spike end
  // raises rec_fire when a burst closes, or recip_fire when the interval adds
  // its reciprocal to the running rate sum.
  always_comb begin
    phase_next         = phase;
    sample_index_next  = sample_index;
    peak_value_next    = peak_value;
    peak_index_next    = peak_index;
    previous_peak_next = previous_peak;
    have_previous_next = have_previous;
    trough_min_next    = trough_min;
    burst_open_next    = burst_open;
    burst_first_next   = burst_first;
    burst_spikes_next  = burst_spikes;
    rate_sum_next      = rate_sum;
    rec_next           = rec;
    rec_fire           = 1'b0;
    recip_fire         = 1'b0;

    unique case (phase)
      PH_LOW: begin
        if (high) begin
          phase_next      = PH_SPIKE;
          peak_value_next = in_item.sample;
          peak_index_next = sample_index;
        end else if (in_item.sample < trough_min) begin
          trough_min_next = in_item.sample;
        end
      end
      PH_SPIKE: begin
        if (high) begin
          if (in_item.sample > peak_value) begin
            peak_value_next = in_item.sample;
            peak_index_next = sample_index;
          end
        end else begin
          // The spike ends: its first maximum becomes a committed peak.
          if (!have_previous) begin
            have_previous_next = 1'b1;
          end else if ((gap > {{(TIME_BITS-GAP_BITS){1'b0}}, gap_samples}) &&
                       (trough_min < trough_level)) begin
            if (burst_open) begin
              rec_fire                = 1'b1;
              rec_next.burst_start    = burst_first;
              rec_next.burst_duration = previous_peak - burst_first;
              rec_next.burst_period   = peak_index - burst_first;
              rec_next.spike_count    = burst_spikes;
              rec_next.mean_rate      = '0;
              rec_next.duty_cycle     = '0;
              rec_next.interburst_gap = gap;
              rec_next.single_spike   = (burst_spikes <= COUNT_BITS'(1));
            end
            burst_open_next   = 1'b1;
            burst_first_next  = peak_index;
            burst_spikes_next = COUNT_BITS'(1);
            rate_sum_next     = '0;
          end else begin
            recip_fire = 1'b1;
            if (burst_open && (burst_spikes != {COUNT_BITS{1'b1}})) begin
              burst_spikes_next = burst_spikes + 1'b1;
            end
          end
          previous_peak_next = peak_index;
          trough_min_next    = in_item.sample;
          phase_next         = PH_LOW;
        end
      end
      default: begin
        if (!high) begin
          phase_next = PH_LOW;
          if (in_item.sample < trough_min) begin
            trough_min_next = in_item.sample;
          end
        end
      end
    endcase

    if (sample_index != {TIME_BITS{1'b1}}) begin
      sample_index_next = sample_index + 1'b1;
    end

    // End of trace: the record of this sample stands, the rest starts over.
    if (in_item.trace_end) begin
      recip_fire         = 1'b0;
      phase_next         = PH_WAIT;
      sample_index_next  = '0;
      peak_value_next    = SAMPLE_MIN;
      peak_index_next    = '0;
      previous_peak_next = '0;
      have_previous_next = 1'b0;
      trough_min_next    = SAMPLE_MAX;
      burst_open_next    = 1'b0;
      burst_first_next   = '0;
      burst_spikes_next  = '0;
      rate_sum_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      sample_index  <= '0;
      peak_value    <= SAMPLE_MIN;
      peak_index    <= '0;
      previous_peak <= '0;
      have_previous <= 1'b0;
      trough_min    <= SAMPLE_MAX;
      burst_open    <= 1'b0;
      burst_first   <= '0;
      burst_spikes  <= '0;
      rate_sum      <= '0;
    end else begin
      if (in_fire) begin
        phase         <= phase_next;
        sample_index  <= sample_index_next;
        peak_value    <= peak_value_next;
        peak_index    <= peak_index_next;
        previous_peak <= previous_peak_next;
        have_previous <= have_previous_next;
        trough_min    <= trough_min_next;
        burst_open    <= burst_open_next;
        burst_first   <= burst_first_next;
        burst_spikes  <= burst_spikes_next;
        rate_sum      <= rate_sum_next;
      end else if ((seq == S_RECIP_WAIT) && div_rsp.done) begin
        rate_sum <= sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];
      end
    end
  end

  // Saturating accumulation of the reciprocal interval.
  assign sum_wide = {1'b0, rate_sum} + (SUM_BITS+1)'(div_rsp.quotient[RATE_BITS-1:0]);

  assign out_load = (seq == S_OUT) && (!out_valid || out_ready);

  // Sequencer around the shared divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
    end else begin
      unique case (seq)
        S_IDLE: begin
          if (in_fire) begin
            if (rec_fire) begin
              seq <= rec_next.single_spike ? S_DUTY_GO : S_RATE_GO;
            end else if (recip_fire) begin
              seq <= S_RECIP_GO;
            end
          end
        end
        S_RATE_GO:  seq <= S_RATE_WAIT;
        S_RATE_WAIT: begin
          if (div_rsp.done) begin
            seq <= S_DUTY_GO;
          end
        end
        S_DUTY_GO: begin
          seq <= (rec.burst_period == '0) ? S_OUT : S_DUTY_WAIT;
        end
        S_DUTY_WAIT: begin
          if (div_rsp.done) begin
            seq <= S_OUT;
          end
        end
        S_RECIP_GO: seq <= S_RECIP_WAIT;
        S_RECIP_WAIT: begin
          if (div_rsp.done) begin
            seq <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            seq <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  // Record under construction and divider operands.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec <= rec_next;
      if (rec_fire) begin
        op_num <= DIV_NUM_BITS'(rate_sum);
        op_den <= DIV_DEN_BITS'(burst_spikes - 1'b1);
      end else begin
        op_num <= ONE_RATE;
        op_den <= (gap == '0) ? DIV_DEN_BITS'(1) : gap;
      end
    end else begin
      if ((seq == S_RATE_WAIT) && div_rsp.done) begin
        rec.mean_rate <= (div_rsp.quotient > ONE_RATE) ? ONE_RATE[RATE_BITS-1:0]
                                                      : div_rsp.quotient[RATE_BITS-1:0];
      end
      if ((seq == S_DUTY_WAIT) && div_rsp.done) begin
        rec.duty_cycle <= (div_rsp.quotient > ONE_DUTY) ? ONE_DUTY[DUTY_BITS-1:0]
                                                       : div_rsp.quotient[DUTY_BITS-1:0];
      end
      if (seq == S_DUTY_GO) begin
        op_num <= {rec.burst_duration, {DUTY_FRAC_BITS{1'b0}}};
        op_den <= rec.burst_period;
      end
    end
  end

  // The duty operands are loaded in S_DUTY_GO, so that divide starts on the
  // first cycle of S_DUTY_WAIT, the only one where the divider is neither
  // running nor reporting.
  assign div_req.start    = (seq == S_RATE_GO) || (seq == S_RECIP_GO) ||
                            ((seq == S_DUTY_WAIT) && !div_rsp.busy && !div_rsp.done);
  assign div_req.dividend = op_num;
  assign div_req.divisor  = op_den;

  sbs_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register: holds a finished record until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= rec;
    end
  end

  `SBS_ASSERT(a_accept_idle, clk, rst, in_fire |-> (seq == S_IDLE), "sample taken mid-sequence")
  `SBS_ASSERT(a_done_waits, clk, rst,
              div_rsp.done |-> ((seq == S_RATE_WAIT) || (seq == S_DUTY_WAIT) ||
                                (seq == S_RECIP_WAIT)),
              "divide result with no consumer")
  `SBS_ASSERT(a_caps, clk, rst,
              out_valid |-> ((out_item.mean_rate <= ONE_RATE[RATE_BITS-1:0]) &&
                             (out_item.duty_cycle <= ONE_DUTY[DUTY_BITS-1:0])),
              "record field past its cap")
  `SBS_ASSERT(a_single_rate, clk, rst,
              (out_valid && out_item.single_spike) |-> (out_item.mean_rate == '0),
              "single-spike burst with a rate")

endmodule

[sim/sbs_checker.sv]
// ----------------------------------------------------------------------------
// Spike burst statistics checker
// Watches the sample, record and register channels of the unit, predicts
// the burst records from the accepted samples and compares them in order.
// ----------------------------------------------------------------------------
module sbs_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  sbs_pkg::sbs_in_t                   in_item,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  sbs_pkg::sbs_out_t                  out_item,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [sbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sbs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                 records_pending,
  output int                                 errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbs_pkg::*;

  typedef enum logic [1:0] {WAIT_LOW = 2'd0, IN_LOW = 2'd1, IN_SPIKE = 2'd2} det_phase_t;

  localparam logic [SUM_BITS-1:0] RATE_SUM_MAX = '1;

  logic signed [SAMPLE_BITS-1:0] spike_lvl, trough_lvl;
  logic [GAP_BITS-1:0]           gap_lim;

  det_phase_t                    phase;
  logic [TIME_BITS-1:0]          idx, peak_idx, prev_peak, first_peak;
  logic signed [SAMPLE_BITS-1:0] peak_val, trough_min;
  logic                          have_prev, burst_open;
  logic [COUNT_BITS-1:0]         spikes;
  logic [SUM_BITS-1:0]           rate_sum;

  sbs_out_t records_due[$];

  task automatic clear_trace();
    phase      = WAIT_LOW;
    idx        = '0;
    peak_val   = SAMPLE_MIN;
    peak_idx   = '0;
    prev_peak  = '0;
    have_prev  = 1'b0;
    trough_min = SAMPLE_MAX;
    burst_open = 1'b0;
    first_peak = '0;
    spikes     = '0;
    rate_sum   = '0;
  endtask

  // A finished spike peaks at p; a long gap with a deep trough closes the
  // open burst into a record and starts a new one at p.
  task automatic commit_peak(input logic [TIME_BITS-1:0] p);
    logic [TIME_BITS-1:0]    gap, dur, per;
    logic [DIV_NUM_BITS-1:0] q;
    logic [SUM_BITS:0]       acc;
    sbs_out_t                rec;
    if (!have_prev) begin
      have_prev = 1'b1;
    end else begin
      gap = p - prev_peak;
      if (gap > {8'd0, gap_lim} && trough_min < trough_lvl) begin
        if (burst_open) begin
          dur = prev_peak - first_peak;
          per = p - first_peak;
          rec = '0;
          rec.burst_start    = first_peak;
          rec.burst_duration = dur;
          rec.burst_period   = per;
          rec.spike_count    = spikes;
          rec.interburst_gap = gap;
          rec.single_spike   = (spikes <= 1);
          if (spikes > 1) begin
            q = {8'd0, rate_sum} / (spikes - 1);
            rec.mean_rate = (q > ONE_RATE) ? ONE_RATE[RATE_BITS-1:0] : q[RATE_BITS-1:0];
          end
          if (per != 0) begin
            q = {dur, 16'd0} / per;
            rec.duty_cycle = (q > ONE_DUTY) ? ONE_DUTY[DUTY_BITS-1:0] : q[DUTY_BITS-1:0];
          end
          records_due.push_back(rec);
        end
        burst_open = 1'b1;
        first_peak = p;
        spikes     = 1;
        rate_sum   = '0;
      end else begin
        q   = ONE_RATE / ((gap != 0) ? gap : 32'd1);
        acc = rate_sum + q[SUM_BITS-1:0];
        rate_sum = (acc > RATE_SUM_MAX) ? RATE_SUM_MAX : acc[SUM_BITS-1:0];
        if (burst_open && spikes != '1) spikes++;
      end
    end
    prev_peak = p;
  endtask

  task automatic take_sample(input sbs_in_t it);
    logic high;
    high = it.sample > spike_lvl;
    case (phase)
      IN_LOW: begin
        if (high) begin
          phase    = IN_SPIKE;
          peak_val = it.sample;
          peak_idx = idx;
        end else if (it.sample < trough_min) begin
          trough_min = it.sample;
        end
      end
      IN_SPIKE: begin
        if (high) begin
          if (it.sample > peak_val) begin
            peak_val = it.sample;
            peak_idx = idx;
          end
        end else begin
          commit_peak(peak_idx);
          trough_min = it.sample;
          phase      = IN_LOW;
        end
      end
      default: begin
        if (!high) begin
          phase = IN_LOW;
          if (it.sample < trough_min) trough_min = it.sample;
        end
      end
    endcase
    if (idx != '1) idx++;
    if (it.trace_end) clear_trace();
  endtask

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: record %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    sbs_out_t want;
    if (rst) begin
      spike_lvl  = SPIKE_LEVEL_RESET;
      trough_lvl = TROUGH_LEVEL_RESET;
      gap_lim    = GAP_SAMPLES_RESET;
      errors     = 0;
      clear_trace();
      records_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPIKE_LEVEL:  spike_lvl  = cfg_data[SAMPLE_BITS-1:0];
          REG_TROUGH_LEVEL: trough_lvl = cfg_data[SAMPLE_BITS-1:0];
          REG_GAP_SAMPLES:  gap_lim    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (records_due.size() == 0) begin
          $display("%0t: record with none expected, start %0d", $realtime, out_item.burst_start);
          errors++;
        end else begin
          want = records_due.pop_front();
          if (out_item.burst_start !== want.burst_start)
            report("burst_start", out_item.burst_start, want.burst_start);
          if (out_item.burst_duration !== want.burst_duration)
            report("burst_duration", out_item.burst_duration, want.burst_duration);
          if (out_item.burst_period !== want.burst_period)
            report("burst_period", out_item.burst_period, want.burst_period);
          if (out_item.spike_count !== want.spike_count)
            report("spike_count", out_item.spike_count, want.spike_count);
          if (out_item.mean_rate !== want.mean_rate)
            report("mean_rate", out_item.mean_rate, want.mean_rate);
          if (out_item.duty_cycle !== want.duty_cycle)
            report("duty_cycle", out_item.duty_cycle, want.duty_cycle);
          if (out_item.interburst_gap !== want.interburst_gap)
            report("interburst_gap", out_item.interburst_gap, want.interburst_gap);
          if (out_item.single_spike !== want.single_spike)
            report("single_spike", out_item.single_spike, want.single_spike);
        end
      end
      // Samples are predicted after the record check so that a record made
      // by this sample can never be matched against itself at this edge.
      if (in_valid && in_ready) take_sample(in_item);
    end
    records_pending = records_due.size();
  end

endmodule

[sim/tb_spike_burst_statistics_unit.sv]
// ----------------------------------------------------------------------------
// Spike burst statistics unit testbench
// Drives synthetic membrane traces through the unit under a series of
// register settings, with random idling on both channels, and lets the
// checker compare every burst record against its own prediction.
// ----------------------------------------------------------------------------
module tb_spike_burst_statistics_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sbs_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  sbs_in_t                   in_item = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  sbs_out_t                  out_item;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_SPIKE_LEVEL;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int records_pending;
  int errors;

  // When quiet is set, neither side idles; used for the final stretch.
  logic quiet = 1'b0;

  // The test keeps its own copy of the levels only to shape the traces.
  int spike_lvl = -3;
  int trough_lvl = -13568;
  int gap_lim = 400;
  int items_sent = 0;

  always #5 clk = ~clk;

  spike_burst_statistics_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sbs_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .records_pending(records_pending), .errors(errors)
  );

  // The record side stalls at random, with runs of
  // readiness in between.
  always @(posedge clk) begin
    int stall_left;
    if (rst || quiet) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if ($urandom_range(7) == 0) begin
      stall_left = $urandom_range(1, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick(input int lo, input int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Sends one item. The handshake is judged at the falling edge, where
  // in_ready already shows what the next rising edge will see.
  task automatic send(input int s, input logic last);
    if (!quiet && $urandom_range(4) == 0) begin
      in_valid <= 1'b0;
      repeat (pick(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item.sample <= s[SAMPLE_BITS-1:0];
    in_item.trace_end <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic stop_items();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every predicted record, then long enough for the divider to
  // finish a spike that may yet make no record.
  task automatic settle();
    @(negedge clk);
    while (records_pending != 0) @(negedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] which, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    // Upper bits of the 16-bit registers are don't-care, so they are random.
    if (which == REG_GAP_SAMPLES) cfg_data <= value[CFG_DATA_BITS-1:0];
    else cfg_data <= {8'($urandom), value[15:0]};
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_levels(input int sl, input int tl, input int g);
    spike_lvl = sl;
    trough_lvl = tl;
    gap_lim = g;
    write_reg(REG_SPIKE_LEVEL, sl);
    write_reg(REG_TROUGH_LEVEL, tl);
    write_reg(REG_GAP_SAMPLES, g);
  endtask

  function automatic int high_value();
    return pick(spike_lvl + 1, 32767);
  endfunction

  // A sample at or below the spike level, and not below the trough level unless that lies above it.
  function automatic int shallow_value();
    return pick((trough_lvl > spike_lvl) ? -32768 : trough_lvl, spike_lvl);
  endfunction

  function automatic int deep_value();
    int lo;
    lo = (trough_lvl > -32768) ? trough_lvl - 1 : -32768;
    return pick(-32768, (lo < spike_lvl) ? lo : spike_lvl);
  endfunction

  task automatic send_spike();
    int w;
    w = pick(1, 3);
    for (int k = 0; k < w; k++) send(high_value(), 1'b0);
  endtask

  // One trace of well-formed bursts: short intra-burst gaps and long,
  // deep gaps between bursts. A little noise is mixed in.
  task automatic send_trace();
    int bursts, n;
    send(shallow_value(), 1'b0);
    bursts = pick(2, 5);
    for (int b = 0; b < bursts; b++) begin
      n = ($urandom_range(4) == 0) ? 1 : pick(2, 6);
      for (int k = 0; k < n; k++) begin
        send_spike();
        if (k < n - 1) begin
          repeat (pick(1, (gap_lim > 4) ? gap_lim / 2 : 1)) begin
            if ($urandom_range(15) == 0) send(int'($urandom_range(65535)) - 32768, 1'b0);
            else send(shallow_value(), 1'b0);
          end
        end
      end
      n = pick(gap_lim + 1, gap_lim + 8);
      for (int k = 0; k < n; k++)
        send((k == n / 2) ? deep_value() : shallow_value(), 1'b0);
    end
    if ($urandom_range(1) == 0) send_spike();
    send(shallow_value(), 1'b1);
  endtask

  task automatic send_noise(input int count);
    for (int k = 0; k < count; k++)
      send(int'($urandom_range(65535)) - 32768, $urandom_range(40) == 0);
  endtask

  task automatic run_phase(input int sl, input int tl, input int g, input int budget);
    int stop_at;
    set_levels(sl, tl, g);
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if (spike_lvl < 32767 && $urandom_range(4) != 0) send_trace();
      else send_noise(pick(5, 30));
    end
    stop_items();
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sample extremes, a sample equal to the spike level, a run
    // that starts high before any low sample, and an end of trace in the
    // middle of a spike, all under the reset register values.
    send(32767, 1'b0);
    send(-3, 1'b0);
    send(-32768, 1'b0);
    send(-2, 1'b0);
    send(32767, 1'b0);
    send(32767, 1'b0);
    send(-3, 1'b0);
    send(0, 1'b0);
    send(100, 1'b1);
    stop_items();
    settle();

    // Directed: tiny gap register, so a lone first spike, a two-spike burst and a
    // closing spike produce one record, for the two-spike burst.
    set_levels(0, -100, 2);
    send(-200, 1'b0);
    send(50, 1'b0);
    for (int k = 0; k < 4; k++) send((k == 1) ? -32768 : -1, 1'b0);
    send(300, 1'b0);
    send(-1, 1'b0);
    send(400, 1'b0);
    for (int k = 0; k < 4; k++) send((k == 2) ? -500 : 0, 1'b0);
    send(10, 1'b0);
    send(-1, 1'b1);
    stop_items();
    settle();

    // Traces run past a phase's budget, so the budgets are kept below the
    // intended share of items.
    run_phase(-3, -13568, 12, 120);
    run_phase(-32768, -32768, 1, 80);      // nothing is below the trough
    run_phase(32767, 32767, 16777215, 60); // nothing is ever high
    run_phase(-32767, 32767, 1, 120);
    run_phase(1000, -8000, 20, 120);
    run_phase(0, 0, 5, 120);
    run_phase(pick(-20000, 20000), pick(-30000, 0), pick(1, 30), 120);
    quiet = 1'b1;
    run_phase(-3, -13568, 8, 120);

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sbs_pkg.sv
rtl/core/sbs_divider.sv
rtl/core/spike_burst_statistics_unit.sv
sim/sbs_checker.sv
sim/tb_spike_burst_statistics_unit.sv
